### hw/rtl/fbm_pkg.sv
// Package of the frame bitmap allocator: sizes, status and command codes,
// channel payload types and the bit search helper.
// No dependencies; every other file of the block but fbm_ram imports it.
package fbm_pkg;

	localparam int BITMAP_WORDS    = 1024;
	localparam int FRAMES_PER_WORD = 32;
	localparam int BIT_AW          = $clog2(FRAMES_PER_WORD);
	localparam int WORD_AW         = $clog2(BITMAP_WORDS);
	localparam int SUM_WORDS       = (BITMAP_WORDS + FRAMES_PER_WORD - 1) / FRAMES_PER_WORD;
	localparam int SUM_AW          = WORD_AW - BIT_AW;
	localparam int FRAME_W         = WORD_AW + BIT_AW;
	localparam int ACTIVE_W        = 11;
	localparam int FIELD_W         = 20;
	localparam int PAGE_SHIFT      = 12;

	localparam logic [31:0] FULL_WORD  = 32'hFFFF_FFFF;
	localparam logic [31:0] FRAME_MASK = 32'hFFFF_F000;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ALREADY = 2'd1;
	localparam logic [1:0] ST_NOFREE  = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [31:0] page_entry;
		logic        user;
		logic        writable;
	} req_t;

	typedef struct packed {
		logic [31:0]        new_entry;
		logic [FRAME_W-1:0] frame_no;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic               en;
		logic [WORD_AW-1:0] addr;
		logic [31:0]        data;
	} bit_wr_t;

	typedef struct packed {
		logic              en;
		logic [SUM_AW-1:0] addr;
		logic [31:0]       data;
	} sum_wr_t;

	// Index of the lowest clear bit; zero when every bit is set.
	function automatic logic [BIT_AW-1:0] lowest_zero(input logic [31:0] v);
		logic [BIT_AW-1:0] idx;
		idx = '0;
		for (int i = 31; i >= 0; i--) begin
			if (!v[i]) idx = BIT_AW'(i);
		end
		return idx;
	endfunction

endpackage

### hw/rtl/fbm_req_if.sv
// Request channel of the frame bitmap allocator: valid, ready and a request item.
// Depends on fbm_pkg for the payload type.
interface fbm_req_if;
	import fbm_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/fbm_rsp_if.sv
// Result channel of the frame bitmap allocator: valid, ready and a result item.
// Depends on fbm_pkg for the payload type.
interface fbm_rsp_if;
	import fbm_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/fbm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fbm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/fbm_out_reg.sv
// Output register of the frame bitmap allocator: holds one result item until taken.
// Depends on fbm_pkg for the result type.
module fbm_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load_valid,
	output logic          load_ready,
	input  fbm_pkg::rsp_t load_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fbm_pkg::rsp_t rsp_data
);
	import fbm_pkg::*;

	logic valid_q;
	rsp_t data_q;

	assign load_ready = !valid_q || rsp_ready;
	assign rsp_valid  = valid_q;
	assign rsp_data   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) data_q <= load_data;
	end
endmodule

### hw/rtl/fbm_ctrl.sv
// Sequencer of the frame bitmap allocator: clearing sweep, group flags, the
// read-modify-write of the summary and bitmap memories, and result formation.
// Depends on fbm_pkg.
module fbm_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  fbm_pkg::req_t                req_data,
	input  logic                         cfg_wr_en,
	input  logic [fbm_pkg::ACTIVE_W-1:0] cfg_wr_data,
	output logic [fbm_pkg::WORD_AW-1:0]  bit_raddr,
	input  logic [31:0]                  bit_rdata,
	output fbm_pkg::bit_wr_t             bit_wr,
	output logic [fbm_pkg::SUM_AW-1:0]   sum_raddr,
	input  logic [31:0]                  sum_rdata,
	output fbm_pkg::sum_wr_t             sum_wr,
	output logic                         res_valid,
	input  logic                         res_ready,
	output fbm_pkg::rsp_t                res_data
);
	import fbm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SUM  = 3'd1;
	localparam logic [2:0] S_BIT  = 3'd2;
	localparam logic [2:0] S_FREE = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]          state_q;
	logic [WORD_AW-1:0]  clr_idx_q;
	logic                clr_done_q;
	logic [ACTIVE_W-1:0] active_q;
	logic [SUM_WORDS-1:0] grp_full_q;
	logic [31:0]         entry_q;
	logic                user_q;
	logic                writable_q;
	logic [SUM_AW-1:0]   grp_q;
	logic [BIT_AW-1:0]   k_q;
	logic [BIT_AW-1:0]   b_q;
	logic [31:0]         sum_q;
	rsp_t                res_q;

	logic [ACTIVE_W-1:0] enabled;
	logic [FIELD_W-1:0]  field;
	logic [SUM_AW-1:0]   grp_pick;
	logic [BIT_AW-1:0]   k_pick;
	logic [BIT_AW-1:0]   b_pick;
	logic [31:0]         word_set;
	logic [31:0]         sum_set;
	logic [FRAME_W-1:0]  pick_frame;
	logic                accept;

	assign enabled   = (active_q > ACTIVE_W'(BITMAP_WORDS)) ? ACTIVE_W'(BITMAP_WORDS) : active_q;
	assign field     = req_data.page_entry[31:PAGE_SHIFT];
	assign req_ready = (state_q == S_IDLE) && clr_done_q;
	assign accept    = req_valid && req_ready;
	assign grp_pick  = SUM_AW'(lowest_zero(32'(grp_full_q)));
	assign k_pick    = lowest_zero(sum_rdata);
	assign b_pick    = lowest_zero(bit_rdata);
	assign word_set  = bit_rdata | (32'd1 << b_pick);
	assign sum_set   = sum_q | (32'd1 << k_q);
	assign pick_frame = {grp_q, k_q, b_pick};
	assign res_valid = (state_q == S_DONE);
	assign res_data  = res_q;

	// Read addresses: request or group flags in idle, summary word in S_SUM, else held.
	always_comb begin
		bit_raddr = {grp_q, k_q};
		sum_raddr = grp_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_data.cmd == CMD_FREE) begin
					bit_raddr = field[FRAME_W-1:BIT_AW];
					sum_raddr = field[FRAME_W-1:WORD_AW];
				end else begin
					sum_raddr = grp_pick;
				end
			end
			S_SUM: bit_raddr = {grp_q, k_pick};
			default: ;
		endcase
	end

	always_comb begin
		bit_wr = '0;
		sum_wr = '0;
		if (!clr_done_q) begin
			bit_wr.en   = 1'b1;
			bit_wr.addr = clr_idx_q;
			sum_wr.en   = (32'(clr_idx_q) < SUM_WORDS);
			sum_wr.addr = clr_idx_q[SUM_AW-1:0];
		end else if (state_q == S_BIT) begin
			bit_wr.en   = 1'b1;
			bit_wr.addr = {grp_q, k_q};
			bit_wr.data = word_set;
			// A word that has just filled up is marked full in its summary word.
			sum_wr.en   = (word_set == FULL_WORD);
			sum_wr.addr = grp_q;
			sum_wr.data = sum_set;
		end else if (state_q == S_FREE) begin
			bit_wr.en   = 1'b1;
			bit_wr.addr = {grp_q, k_q};
			bit_wr.data = bit_rdata & ~(32'd1 << b_q);
			sum_wr.en   = 1'b1;
			sum_wr.addr = grp_q;
			sum_wr.data = sum_rdata & ~(32'd1 << k_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			clr_idx_q  <= '0;
			clr_done_q <= 1'b0;
			active_q   <= ACTIVE_W'(BITMAP_WORDS);
			grp_full_q <= '0;
		end else begin
			if (cfg_wr_en) active_q <= cfg_wr_data;
			if (!clr_done_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == WORD_AW'(BITMAP_WORDS - 1)) clr_done_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_data.cmd == CMD_ALLOC) begin
							if (field != '0 || (&grp_full_q)) state_q <= S_DONE;
							else state_q <= S_SUM;
						end else begin
							if (field == '0 || 15'(field >> BIT_AW) >= 15'(enabled))
								state_q <= S_DONE;
							else
								state_q <= S_FREE;
						end
					end
				end
				S_SUM: begin
					if (ACTIVE_W'({grp_q, k_pick}) >= enabled) state_q <= S_DONE;
					else state_q <= S_BIT;
				end
				S_BIT: begin
					if (word_set == FULL_WORD && sum_set == FULL_WORD)
						grp_full_q[grp_q] <= 1'b1;
					state_q <= S_DONE;
				end
				S_FREE: begin
					grp_full_q[grp_q] <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers; the result defaults to a failure with the entry unchanged.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					entry_q    <= req_data.page_entry;
					user_q     <= req_data.user;
					writable_q <= req_data.writable;
					res_q.new_entry <= req_data.page_entry;
					res_q.frame_no  <= '0;
					if (req_data.cmd == CMD_ALLOC) begin
						grp_q <= grp_pick;
						if (field != '0) res_q.status <= ST_ALREADY;
						else res_q.status <= ST_NOFREE;
					end else begin
						grp_q <= field[FRAME_W-1:WORD_AW];
						k_q   <= field[WORD_AW-1:BIT_AW];
						b_q   <= field[BIT_AW-1:0];
						if (field == '0) res_q.status <= ST_ALREADY;
						else res_q.status <= ST_RANGE;
					end
				end
			end
			S_SUM: begin
				k_q   <= k_pick;
				sum_q <= sum_rdata;
			end
			S_BIT: begin
				res_q.new_entry <= entry_q | (32'(pick_frame) << PAGE_SHIFT)
					| {29'd0, user_q, writable_q, 1'b1};
				res_q.frame_no <= pick_frame;
				res_q.status   <= ST_OK;
			end
			S_FREE: begin
				res_q.new_entry <= entry_q & ~FRAME_MASK;
				res_q.frame_no  <= {grp_q, k_q, b_q};
				res_q.status    <= ST_OK;
			end
			default: ;
		endcase
	end
endmodule

### hw/rtl/frame_bitmap_allocator.sv
// Frame bitmap allocator: top level joining the sequencer, the two memories and
// the output register. Depends on fbm_pkg, fbm_req_if, fbm_rsp_if, fbm_ram,
// fbm_out_reg and fbm_ctrl.
//
// Requests come in on req: an allocate item claims the lowest free frame below
// the active word limit and returns the page entry with the frame and present bits
// set and the request's user and writable flags ORed in; a free item releases the
// entry's frame and zeroes its frame field. Every item gives exactly one result
// item on rsp. active_words is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle; the block does not enforce this.
// One item is handled at a time. An allocate reaches the result register through
// a summary word read, a bitmap word read and a bitmap write-back; a free reads
// both words and writes them back; an item that fails its checks, or an allocate
// that finds no free frame below the limit after its summary word read, goes
// straight to the result. The next item is accepted the cycle after the result is loaded.
// After reset a clearing sweep writes zeros to the bitmap, one word a cycle;
// req.ready stays low until it is done.
// When the receiver stalls, the result waits in the output register and the
// next item is still taken and worked on up to its own result.
module frame_bitmap_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	fbm_req_if.sink                      req,
	fbm_rsp_if.source                    rsp,
	input  logic                         cfg_wr_en,
	input  logic [fbm_pkg::ACTIVE_W-1:0] cfg_wr_data
);
	import fbm_pkg::*;

	logic [WORD_AW-1:0] bit_raddr;
	logic [31:0]        bit_rdata;
	bit_wr_t            bit_wr;
	logic [SUM_AW-1:0]  sum_raddr;
	logic [31:0]        sum_rdata;
	sum_wr_t            sum_wr;
	logic               res_valid;
	logic               res_ready;
	rsp_t               res_data;

	fbm_ram #(.WIDTH(32), .DEPTH(BITMAP_WORDS)) u_bit_ram (
		.clk   (clk),
		.we    (bit_wr.en),
		.waddr (bit_wr.addr),
		.wdata (bit_wr.data),
		.raddr (bit_raddr),
		.rdata (bit_rdata)
	);

	// Bit k of summary word g is set when bitmap word g*32+k is full.
	fbm_ram #(.WIDTH(32), .DEPTH(SUM_WORDS)) u_sum_ram (
		.clk   (clk),
		.we    (sum_wr.en),
		.waddr (sum_wr.addr),
		.wdata (sum_wr.data),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	fbm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.req_data    (req.data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.bit_raddr   (bit_raddr),
		.bit_rdata   (bit_rdata),
		.bit_wr      (bit_wr),
		.sum_raddr   (sum_raddr),
		.sum_rdata   (sum_rdata),
		.sum_wr      (sum_wr),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_data    (res_data)
	);

	fbm_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (res_valid),
		.load_ready (res_ready),
		.load_data  (res_data),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_data   (rsp.data)
	);
endmodule

### hw/rtl/fbm_chk.sv
// Port-level checker of the frame bitmap allocator, bound to the top level.
// Depends on fbm_pkg and frame_bitmap_allocator.
module fbm_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input fbm_pkg::rsp_t rsp_data
);
	import fbm_pkg::*;

	// Items are handled one at a time, so ready drops after every acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while an item is in work");

	// A failed item reports no frame.
	a_fail_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |-> rsp_data.frame_no == '0)
		else $error("failed item carries a frame index");

	// A good result is either a free (frame field zeroed) or an allocation whose
	// frame field matches the reported frame and whose present bit is set.
	a_ok_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_OK |->
			(rsp_data.new_entry[31:PAGE_SHIFT] == '0 && rsp_data.frame_no != '0) ||
			(rsp_data.new_entry[31:PAGE_SHIFT] == 20'(rsp_data.frame_no) &&
			 rsp_data.new_entry[0]))
		else $error("good result with inconsistent entry");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result item changed");
endmodule

bind frame_bitmap_allocator fbm_chk u_fbm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

### tb/sv/frame_bitmap_allocator_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for frame_bitmap_allocator: directed and random allocate and free items
// under several active-word limits, each result checked against an in-bench bitmap model.
// Depends on fbm_pkg, fbm_req_if, fbm_rsp_if and the allocator RTL.
module frame_bitmap_allocator_tb;
	import fbm_pkg::*;

	localparam int unsigned WAIT_MAX    = 18;
	localparam int unsigned HOLD_LEN    = 300;
	localparam int unsigned STALL_LIMIT = 8000;
	localparam int unsigned SETTLE      = 20;
	localparam int unsigned PHASES      = 9;

	// Active-word limit, item count and allocate share (percent) of each random phase.
	localparam int unsigned PHASE_WORDS [PHASES] = '{1, 0, 2, 2047, 3, 1024, 1025, 5, 1};
	localparam int unsigned PHASE_ITEMS [PHASES] = '{180, 60, 200, 260, 200, 420, 150, 250, 150};
	localparam int unsigned PHASE_ALLOC [PHASES] = '{60, 50, 55, 65, 60, 60, 55, 60, 45};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [ACTIVE_W-1:0] cfg_wr_data;

	fbm_req_if req_ch ();
	fbm_rsp_if rsp_ch ();

	frame_bitmap_allocator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Bitmap model and the limit it is scanned under.
	logic [31:0]         frame_bits [BITMAP_WORDS];
	logic [ACTIVE_W-1:0] words_enabled;
	logic [31:0]         owned_entries [$];
	req_t                req_backlog [$];
	rsp_t                outcomes_due [$];

	int unsigned items_queued, results_checked, mismatches, limits_used, long_holds;
	int unsigned status_tally [4];
	int unsigned req_wait, req_mode_left, rsp_wait, rsp_mode_left, rsp_taken, idle_cycles;
	bit          req_calm, rsp_calm;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_t allocate_or_release(input req_t item);
		rsp_t               r;
		logic [FIELD_W-1:0] field;
		int unsigned        limit;
		int                 frame;
		frame = -1;
		field = item.page_entry[31:PAGE_SHIFT];
		limit = (words_enabled > BITMAP_WORDS) ? BITMAP_WORDS : words_enabled;
		r.new_entry = item.page_entry;
		r.frame_no = '0;
		if (item.cmd == CMD_ALLOC) begin
			if (field != '0) begin
				r.status = ST_ALREADY;
			end else begin
				for (int w = 0; w < limit && frame < 0; w++) begin
					if (frame_bits[w] != FULL_WORD) begin
						for (int b = 0; b < FRAMES_PER_WORD && frame < 0; b++) begin
							if (!frame_bits[w][b]) frame = w * FRAMES_PER_WORD + b;
						end
					end
				end
				if (frame < 0) begin
					r.status = ST_NOFREE;
				end else begin
					frame_bits[frame / FRAMES_PER_WORD][frame % FRAMES_PER_WORD] = 1'b1;
					r.new_entry = item.page_entry | ((32'(frame) << PAGE_SHIFT) & FRAME_MASK)
						| {29'd0, item.user, item.writable, 1'b1};
					r.frame_no = FRAME_W'(frame);
					r.status = ST_OK;
					owned_entries.push_back(r.new_entry);
				end
			end
		end else if (field == '0) begin
			r.status = ST_ALREADY;
		end else if ((field / FRAMES_PER_WORD) >= limit) begin
			r.status = ST_RANGE;
		end else begin
			// A frame whose bit is already clear is released all the same.
			frame_bits[field / FRAMES_PER_WORD][field % FRAMES_PER_WORD] = 1'b0;
			r.new_entry = item.page_entry & ~FRAME_MASK;
			r.frame_no = FRAME_W'(field);
			r.status = ST_OK;
		end
		return r;
	endfunction

	task automatic offer(input logic cmd, input logic [31:0] entry, input logic user,
			input logic writable);
		req_t item;
		item.cmd = cmd;
		item.page_entry = entry;
		item.user = user;
		item.writable = writable;
		while (req_backlog.size() >= 2) @(posedge clk);
		req_backlog.push_back(item);
		items_queued++;
	endtask

	// The limit is only changed once every item sent so far has come back.
	task automatic set_word_limit(input int unsigned words);
		while (results_checked != items_queued) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ACTIVE_W'(words);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		words_enabled = ACTIVE_W'(words);
		limits_used++;
	endtask

	task automatic random_item(input int unsigned alloc_share);
		int unsigned pick, idx;
		logic [31:0] entry;
		logic [19:0] field;
		pick = $urandom_range(0, 99);
		if (pick < alloc_share || (pick >= alloc_share + 17 && owned_entries.size() == 0)) begin
			offer(CMD_ALLOC, {20'h0, 12'($urandom)}, 1'($urandom), 1'($urandom));
		end else if (pick < alloc_share + 6) begin
			field = 20'($urandom_range(1, 20'hFFFFF));
			offer(CMD_ALLOC, {field, 12'($urandom)}, 1'($urandom), 1'($urandom));
		end else if (pick < alloc_share + 9) begin
			offer(CMD_FREE, {20'h0, 12'($urandom)}, 1'($urandom), 1'($urandom));
		end else if (pick < alloc_share + 17) begin
			field = $urandom_range(0, 1) ? 20'($urandom_range(1, 32767))
				: 20'($urandom_range(1, 20'hFFFFF));
			offer(CMD_FREE, {field, 12'($urandom)}, 1'($urandom), 1'($urandom));
		end else begin
			// Release an entry that was handed out; now and then keep it for a second release.
			idx = $urandom_range(0, owned_entries.size() - 1);
			entry = owned_entries[idx];
			if ($urandom_range(0, 7) != 0) owned_entries.delete(idx);
			offer(CMD_FREE, {entry[31:PAGE_SHIFT], 12'($urandom)}, 1'($urandom), 1'($urandom));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (!req_ch.valid || req_ch.ready) begin
				if (req_wait != 0) begin
					req_ch.valid <= 1'b0;
					req_wait <= req_wait - 1;
				end else if (req_backlog.size() != 0) begin
					req_ch.valid <= 1'b1;
					req_ch.data <= req_backlog.pop_front();
					req_wait <= req_calm ? 0 : $urandom_range(0, WAIT_MAX);
					if (req_mode_left == 0) begin
						req_calm <= !req_calm;
						req_mode_left <= $urandom_range(20, 80);
					end else begin
						req_mode_left <= req_mode_left - 1;
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		int unsigned hold;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_taken <= rsp_taken + 1;
				// A long hold-off now and then lets the block fill up and stall its input.
				if (rsp_taken % 500 == 250) begin
					hold = HOLD_LEN;
					long_holds++;
				end else begin
					hold = rsp_calm ? 0 : $urandom_range(0, WAIT_MAX);
				end
				if (rsp_mode_left == 0) begin
					rsp_calm <= !rsp_calm;
					rsp_mode_left <= $urandom_range(20, 80);
				end else begin
					rsp_mode_left <= rsp_mode_left - 1;
				end
				rsp_ch.ready <= (hold == 0);
				rsp_wait <= (hold == 0) ? 0 : hold - 1;
			end else if (rsp_wait != 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_wait <= rsp_wait - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rsp_t due;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) outcomes_due.push_back(allocate_or_release(req_ch.data));
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (outcomes_due.size() == 0) begin
					$display("%0t: result with nothing outstanding, got entry %h frame %0d status %0d",
						$time, rsp_ch.data.new_entry, rsp_ch.data.frame_no, rsp_ch.data.status);
					mismatches++;
				end else begin
					due = outcomes_due.pop_front();
					if (rsp_ch.data.new_entry !== due.new_entry) begin
						$display("%0t: new_entry expected %h got %h",
							$time, due.new_entry, rsp_ch.data.new_entry);
						mismatches++;
					end
					if (rsp_ch.data.frame_no !== due.frame_no) begin
						$display("%0t: frame number expected %0d got %0d",
							$time, due.frame_no, rsp_ch.data.frame_no);
						mismatches++;
					end
					if (rsp_ch.data.status !== due.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, due.status, rsp_ch.data.status);
						mismatches++;
					end
					status_tally[due.status]++;
					results_checked++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("frame_bitmap_allocator_tb: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		arst_n = 1'b0;
		words_enabled = ACTIVE_W'(1024);
		foreach (frame_bits[w]) frame_bits[w] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Frame zero goes out first, so releasing its entry finds a zero frame field.
		offer(CMD_ALLOC, 32'h0000_0000, 1'b0, 1'b0);
		offer(CMD_FREE,  32'h0000_0001, 1'b0, 1'b0);
		offer(CMD_ALLOC, 32'h0000_0FFF, 1'b1, 1'b1);
		offer(CMD_ALLOC, 32'h0000_0A50, 1'b1, 1'b0);
		offer(CMD_ALLOC, 32'h0000_0000, 1'b0, 1'b1);
		offer(CMD_ALLOC, 32'hFFFF_F000, 1'b1, 1'b1);
		offer(CMD_ALLOC, 32'h0000_1000, 1'b0, 1'b0);
		offer(CMD_FREE,  32'h0000_1FFF, 1'b1, 1'b1);
		offer(CMD_FREE,  32'h0000_1000, 1'b0, 1'b0);
		offer(CMD_ALLOC, 32'h0000_0000, 1'b1, 1'b0);
		offer(CMD_FREE,  32'h07FF_F123, 1'b0, 1'b1);
		offer(CMD_FREE,  32'h0800_0ABC, 1'b0, 1'b0);
		offer(CMD_FREE,  32'hFFFF_FFFF, 1'b1, 1'b1);
		offer(CMD_FREE,  32'h0000_0FFF, 1'b0, 1'b0);
		offer(CMD_FREE,  32'h0000_2000, 1'b0, 1'b0);
		offer(CMD_FREE,  32'h0000_3555, 1'b1, 1'b0);
		// With no words enabled nothing can be allocated and every frame is out of range.
		set_word_limit(0);
		offer(CMD_ALLOC, 32'h0000_0000, 1'b1, 1'b1);
		offer(CMD_FREE,  32'h0000_1000, 1'b0, 1'b0);
		offer(CMD_ALLOC, 32'hFFFF_F000, 1'b0, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			set_word_limit(PHASE_WORDS[p]);
			repeat (PHASE_ITEMS[p]) random_item(PHASE_ALLOC[p]);
		end

		while (results_checked != items_queued) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("Checked %0d results under %0d word limits, with %0d long receiver hold-offs.",
			results_checked, limits_used, long_holds);
		$display("Outcomes: %0d ok, %0d already set or free, %0d no free frame, %0d out of range.",
			status_tally[ST_OK], status_tally[ST_ALREADY], status_tally[ST_NOFREE],
			status_tally[ST_RANGE]);
		if (mismatches == 0) begin
			$display("frame_bitmap_allocator_tb: PASS");
		end else begin
			$display("frame_bitmap_allocator_tb: FAIL");
		end
		$finish;
	end

endmodule
